/* rtl/sbl_pkg.sv */
// Shared constants and codes for the 3x3 Sobel edge magnitude core.
// No dependencies; compiled before every other file of the block.
package sbl_pkg;

	// default geometry and sample size
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_PIXEL_BITS = 8;

	// port field widths
	localparam int PIXEL_W     = 8;
	localparam int EDGE_W      = 8;
	localparam int OUT_COL_W   = 10;
	localparam int ROW_W       = 12;
	localparam int FRAME_W_W   = 11;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_IDX_W   = 1;
	localparam int S_TDATA_W   = 8;
	localparam int M_TDATA_W   = 32;

	// register reset values
	localparam logic [FRAME_W_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [ROW_W-1:0]     FRAME_HEIGHT_RST = 12'd480;

	// smallest legal frame edge, saturation limit of the result
	localparam int MIN_DIM    = 3;
	localparam int EDGE_LIMIT = 255;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

endpackage

/* rtl/sbl_line_buf.sv */
// Two-row line store for the Sobel core: one word per column holds the
// row above and the row two above. Registered read. Uses no package.
module sbl_line_buf #(
	parameter int DEPTH = 1024,
	parameter int PB    = 8
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [2*PB-1:0]          rd_data,   // [PB-1:0] two above, [2PB-1:PB] above
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [2*PB-1:0]          wr_data
);

	logic [2*PB-1:0] mem [DEPTH];
	logic [2*PB-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/sbl_gradient.sv */
// Sobel |gx| + |gy| over a 3x3 window, saturated to the result width.
// Depends on sbl_pkg for the limit and result width.
module sbl_gradient #(
	parameter int PB = 8
) (
	input  logic [2:0][2:0][PB-1:0]      win,   // win[row][col], row 0 top, col 2 newest
	output logic [sbl_pkg::EDGE_W-1:0]   edge_value
);
	import sbl_pkg::*;

	localparam int GW = PB + 2;
	localparam int SW = (PB + 3 > EDGE_W + 1) ? PB + 3 : EDGE_W + 1;

	logic [GW-1:0] gxp, gxn, gyp, gyn, adx, ady;
	logic [SW-1:0] sum;

	always_comb begin
		gxp = GW'(win[0][2]) + (GW'(win[1][2]) << 1) + GW'(win[2][2]);
		gxn = GW'(win[0][0]) + (GW'(win[1][0]) << 1) + GW'(win[2][0]);
		gyp = GW'(win[2][0]) + (GW'(win[2][1]) << 1) + GW'(win[2][2]);
		gyn = GW'(win[0][0]) + (GW'(win[0][1]) << 1) + GW'(win[0][2]);
		adx = (gxp >= gxn) ? gxp - gxn : gxn - gxp;
		ady = (gyp >= gyn) ? gyp - gyn : gyn - gyp;
		sum = SW'(adx) + SW'(ady);
		edge_value = (sum > SW'(EDGE_LIMIT)) ? EDGE_W'(EDGE_LIMIT) : sum[EDGE_W-1:0];
	end

endmodule

/* rtl/sobel_edge_magnitude_3x3_core.sv */
// Top level of the streaming 3x3 Sobel edge magnitude core.
// Needs sbl_pkg, sbl_line_buf and sbl_gradient.
// Path: an accepted pixel passes the stage 1 registers and line store read, the window
// and stage 2 tags, then the output register; each may hold while the output stalls.
// Throughput: one pixel per clock unless stalled; line store has one read, one write port.
// Reset: counters, valids and window clear; width/height go to 640/480; line store kept.
module sobel_edge_magnitude_3x3_core #(
	parameter int MAX_WIDTH  = sbl_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = sbl_pkg::DEF_PIXEL_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [sbl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sbl_pkg::CFG_DATA_W-1:0]    cfg_data,
	// pixel input
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sbl_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] pixel
	// edge result output
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sbl_pkg::M_TDATA_W-1:0]     m_tdata,   // [7:0] edge_value, [17:8] out_col,
	                                                     // [29:18] out_row, [31:30] zero
	output logic                              m_tlast    // frame_end
);
	import sbl_pkg::*;

	localparam int PB = PIXEL_BITS;
	localparam int CW = $clog2(MAX_WIDTH);                 // column counter / line store address
	localparam int WW = ($clog2(MAX_WIDTH + 1) > FRAME_W_W) ? $clog2(MAX_WIDTH + 1) : FRAME_W_W;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [FRAME_W_W-1:0] frame_width_q;
	logic [ROW_W-1:0]     frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FRAME_W_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
			endcase
		end
	end

	// effective geometry: width clamped to [3, MAX_WIDTH], height to at least 3
	logic [WW-1:0]    fw_ext, eff_w;
	logic [CW-1:0]    col_last;
	logic [ROW_W-1:0] row_last;

	always_comb begin
		fw_ext = WW'(frame_width_q);
		if (fw_ext < WW'(MIN_DIM))
			eff_w = WW'(MIN_DIM);
		else if (fw_ext > WW'(MAX_WIDTH))
			eff_w = WW'(MAX_WIDTH);
		else
			eff_w = fw_ext;
		col_last = CW'(eff_w - WW'(1));
		row_last = (frame_height_q < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM - 1)
		                                              : frame_height_q - ROW_W'(1);
	end

	// ---------------------------------------------------------------
	// handshake: each stage moves when the one after it has room
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2;
	logic emit_s1, emit_s2;
	logic m_tvalid_q;
	logic out_ld, ready2, ready1, accept, adv1;

	assign out_ld   = !m_tvalid_q || m_tready;
	assign ready2   = !valid_s2 || !emit_s2 || out_ld;   // non-emitting words just drop
	assign ready1   = !valid_s1 || ready2;
	assign s_tready = ready1;
	assign accept   = s_tvalid && ready1;
	assign adv1     = valid_s1 && ready2;

	// ---------------------------------------------------------------
	// stage 0: raster position, line store read
	// ---------------------------------------------------------------
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             col_wrap, row_wrap;

	assign col_wrap = (col_q == col_last);
	assign row_wrap = (row_q == row_last);

	// a config write restarts the frame; line store and window are kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 1 registers: pixel, address and result tags
	// ---------------------------------------------------------------
	logic [PB-1:0]        px_s1;
	logic [CW-1:0]        col_s1;
	logic [OUT_COL_W-1:0] ocol_s1, ocol_s2;
	logic [ROW_W-1:0]     orow_s1, orow_s2;
	logic                 last_s1, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else if (ready1) begin
			valid_s1 <= s_tvalid;
			// window is complete around (c-1, r-1) once c >= 2 and r >= 2
			emit_s1  <= (col_q >= CW'(2)) && (row_q >= ROW_W'(2));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= PB'(s_tdata);
			col_s1  <= col_q;
			ocol_s1 <= OUT_COL_W'(col_q - CW'(1));
			orow_s1 <= row_q - ROW_W'(1);
			last_s1 <= col_wrap && row_wrap;
		end
	end

	// line store: read at accept, write back {pixel, row above} when stage 1 moves.
	// The same column comes round again only a full row later, so no bypass.
	logic [2*PB-1:0] lb_rd;
	logic [PB-1:0]   top_s1, mid_s1;

	sbl_line_buf #(
		.DEPTH (MAX_WIDTH),
		.PB    (PB)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (lb_rd),
		.wr_en   (adv1),
		.wr_addr (col_s1),
		.wr_data ({px_s1, mid_s1})
	);

	assign top_s1 = lb_rd[PB-1:0];
	assign mid_s1 = lb_rd[2*PB-1:PB];

	// 3x3 window: shifts left when stage 1 moves, newest column enters at col 2.
	// It holds still while stage 2 waits, so stage 2 reads it directly.
	logic [2:0][2:0][PB-1:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= top_s1;
			win_q[1][2] <= mid_s1;
			win_q[2][2] <= px_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: tags beside the settled window
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			emit_s2  <= 1'b0;
		end else if (ready2) begin
			valid_s2 <= valid_s1;
			emit_s2  <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ocol_s2 <= ocol_s1;
			orow_s2 <= orow_s1;
			last_s2 <= last_s1;
		end
	end

	logic [EDGE_W-1:0] edge_s2;

	sbl_gradient #(
		.PB (PB)
	) u_gradient (
		.win        (win_q),
		.edge_value (edge_s2)
	);

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	logic [EDGE_W-1:0]    edge_q;
	logic [OUT_COL_W-1:0] ocol_q;
	logic [ROW_W-1:0]     orow_q;
	logic                 last_q;
	logic                 load_out;

	assign load_out = out_ld && valid_s2 && emit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_ld) begin
			m_tvalid_q <= valid_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			edge_q <= edge_s2;
			ocol_q <= ocol_s2;
			orow_q <= orow_s2;
			last_q <= last_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({orow_q, ocol_q, edge_q});
	assign m_tlast  = last_q;

endmodule

/* rtl/sbl_checker.sv */
// Port-level checks for the Sobel core, bound to the top level below.
// Depends on sbl_pkg and sobel_edge_magnitude_3x3_core.
module sbl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [sbl_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                           m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// with the output register empty the whole pipe has room
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a fresh result must be preceded by an accepted pixel
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
		else $error("result without matching pixel");

	// padding bits above the row field stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:30] == 2'b00)
		else $error("nonzero padding in result word");

endmodule

bind sobel_edge_magnitude_3x3_core sbl_checker u_sbl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
